@@ hdl/qpcn_pkg.sv @@
package qpcn_pkg;

	localparam int COORD_WIDTH      = 32;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int NORMAL_WIDTH     = NORMAL_FRAC_BITS + 2;

	localparam int DIFF_W  = COORD_WIDTH + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int BL_W    = $clog2(CROSS_W + 1);
	localparam int MAG_W   = 31;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int ROOT_W  = 32;
	localparam int SUM_W   = 2 * ROOT_W;
	localparam int DIVD_W  = ROOT_W + NORMAL_FRAC_BITS;
	localparam int QUO_W   = NORMAL_FRAC_BITS + 1;

	typedef logic signed [COORD_WIDTH-1:0]  coord_t;
	typedef logic signed [NORMAL_WIDTH-1:0] normal_t;

	typedef struct packed {
		coord_t corner0_x;
		coord_t corner0_y;
		coord_t corner0_z;
		coord_t corner1_x;
		coord_t corner1_y;
		coord_t corner1_z;
		coord_t corner2_x;
		coord_t corner2_y;
		coord_t corner2_z;
		coord_t corner3_x;
		coord_t corner3_y;
		coord_t corner3_z;
	} quad_t;

	typedef struct packed {
		coord_t  center_x;
		coord_t  center_y;
		coord_t  center_z;
		normal_t normal_x;
		normal_t normal_y;
		normal_t normal_z;
		logic    degenerate;
	} plane_t;

	// index 0 is x, 1 is y, 2 is z
	typedef struct packed {
		logic [2:0][COORD_WIDTH-1:0] center;
		logic [2:0][CROSS_W-1:0]     cross_mag;
		logic [2:0]                  neg;
		logic                        degenerate;
	} plane_job_t;

endpackage

@@ hdl/qpcn_front.sv @@
module qpcn_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                quad_valid,
	output logic                quad_stall,
	input  qpcn_pkg::quad_t     quad,
	output logic                job_valid,
	input  logic                job_full,
	output qpcn_pkg::plane_job_t job
);

	localparam int CW = qpcn_pkg::COORD_WIDTH;
	localparam int DW = qpcn_pkg::DIFF_W;
	localparam int PW = qpcn_pkg::PROD_W;
	localparam int XW = qpcn_pkg::CROSS_W;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [CW-1:0] c0 [3];
	logic signed [CW-1:0] c1 [3];
	logic signed [CW-1:0] c2 [3];
	logic signed [CW-1:0] c3 [3];

	logic signed [CW+1:0] sum4 [3];
	logic signed [DW-1:0] e1_d [3];
	logic signed [DW-1:0] e2_d [3];

	logic [2:0][CW-1:0]   center_s1, center_s2, center_s3;
	logic signed [DW-1:0] e1_s1 [3];
	logic signed [DW-1:0] e2_s1 [3];
	logic signed [PW-1:0] prod_s2 [6];
	logic signed [XW-1:0] cross_s3 [3];
	qpcn_pkg::plane_job_t job_s4;

	function automatic logic signed [CW+1:0] sx2(input logic signed [CW-1:0] v);
		return {{2{v[CW-1]}}, v};
	endfunction

	assign c0[0] = quad.corner0_x; assign c0[1] = quad.corner0_y; assign c0[2] = quad.corner0_z;
	assign c1[0] = quad.corner1_x; assign c1[1] = quad.corner1_y; assign c1[2] = quad.corner1_z;
	assign c2[0] = quad.corner2_x; assign c2[1] = quad.corner2_y; assign c2[2] = quad.corner2_z;
	assign c3[0] = quad.corner3_x; assign c3[1] = quad.corner3_y; assign c3[2] = quad.corner3_z;

	// hold everything while the last stage waits on a full queue
	assign adv        = !(v_s4 && job_full);
	assign quad_stall = !adv;
	assign job_valid  = v_s4;
	assign job        = job_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum4[i] = sx2(c0[i]) + sx2(c1[i]) + sx2(c2[i]) + sx2(c3[i]);
			e1_d[i] = {c1[i][CW-1], c1[i]} - {c0[i][CW-1], c0[i]};
			e2_d[i] = {c2[i][CW-1], c2[i]} - {c0[i][CW-1], c0[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= quad_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				// floor divide by four: drop the two low bits of the exact sum
				center_s1[i] <= sum4[i][CW+1:2];
				e1_s1[i]     <= e1_d[i];
				e2_s1[i]     <= e2_d[i];
			end
			center_s2  <= center_s1;
			prod_s2[0] <= e1_s1[1] * e2_s1[2];
			prod_s2[1] <= e1_s1[2] * e2_s1[1];
			prod_s2[2] <= e1_s1[2] * e2_s1[0];
			prod_s2[3] <= e1_s1[0] * e2_s1[2];
			prod_s2[4] <= e1_s1[0] * e2_s1[1];
			prod_s2[5] <= e1_s1[1] * e2_s1[0];
			center_s3  <= center_s2;
			for (int i = 0; i < 3; i++) begin
				cross_s3[i] <= XW'(prod_s2[2*i]) - XW'(prod_s2[2*i+1]);
			end
			job_s4.center     <= center_s3;
			job_s4.degenerate <= (cross_s3[0] == '0) && (cross_s3[1] == '0)
				&& (cross_s3[2] == '0);
			for (int i = 0; i < 3; i++) begin
				job_s4.neg[i]       <= cross_s3[i][XW-1];
				job_s4.cross_mag[i] <= cross_s3[i][XW-1] ? XW'(-cross_s3[i]) : cross_s3[i];
			end
		end
	end

endmodule

@@ hdl/qpcn_queue.sv @@
module qpcn_queue #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  qpcn_pkg::plane_job_t wr_data,
	output logic                 full,
	input  logic                 pop,
	output qpcn_pkg::plane_job_t rd_data,
	output logic                 empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	qpcn_pkg::plane_job_t mem_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/qpcn_back.sv @@
module qpcn_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	input  qpcn_pkg::plane_job_t job,
	output logic                 job_pop,
	output logic                 plane_valid,
	input  logic                 plane_stall,
	output qpcn_pkg::plane_t     plane
);

	localparam int CW  = qpcn_pkg::COORD_WIDTH;
	localparam int NF  = qpcn_pkg::NORMAL_FRAC_BITS;
	localparam int NW  = qpcn_pkg::NORMAL_WIDTH;
	localparam int XW  = qpcn_pkg::CROSS_W;
	localparam int BW  = qpcn_pkg::BL_W;
	localparam int MW  = qpcn_pkg::MAG_W;
	localparam int SQW = qpcn_pkg::SQ_W;
	localparam int RW  = qpcn_pkg::ROOT_W;
	localparam int SW  = qpcn_pkg::SUM_W;
	localparam int DVW = qpcn_pkg::DIVD_W;
	localparam int QW  = qpcn_pkg::QUO_W;
	localparam int NB  = 5 + RW + 1 + QW + 1;

	typedef struct packed {
		logic [2:0][CW-1:0] center;
		logic [2:0][MW-1:0] mag;
		logic [2:0]         neg;
		logic               degenerate;
	} side_t;

	typedef struct packed {
		logic [SW-1:0] rem;
		logic [SW-1:0] root;
	} root_t;

	logic          adv;
	logic [NB-1:0] vld_s;

	qpcn_pkg::plane_job_t job_s1, job_s2;
	logic [XW-1:0]        orv_s1;
	logic [BW-1:0]        bl_s2;
	side_t                side_s3, side_s4, side_s5;
	logic [2:0][SQW-1:0]  sq_s4;
	logic [SW-1:0]        sum_s5;
	logic [BW-1:0]        shift_amt;

	root_t                root_sr [RW+1];
	side_t                side_sr [RW+1];

	logic [2:0][DVW-1:0]  rem_sd  [QW+1];
	logic [2:0][QW-1:0]   quo_sd  [QW+1];
	logic [RW-1:0]        div_sd  [QW+1];
	side_t                side_sd [QW+1];

	qpcn_pkg::plane_t     out_q;

	function automatic logic [BW-1:0] bitlen(input logic [XW-1:0] v);
		logic [BW-1:0] n;
		n = '0;
		for (int i = 0; i < XW; i++) begin
			if (v[i]) n = BW'(i + 1);
		end
		return n;
	endfunction

	function automatic root_t root_step(input root_t a, input logic [SW-1:0] b);
		root_t         r;
		logic [SW-1:0] t;
		t = a.root + b;
		if (a.rem >= t) begin
			r.rem  = a.rem - t;
			r.root = (a.root >> 1) + b;
		end else begin
			r.rem  = a.rem;
			r.root = a.root >> 1;
		end
		return r;
	endfunction

	assign adv         = !(vld_s[NB-1] && plane_stall);
	assign job_pop     = adv && job_valid;
	assign plane_valid = vld_s[NB-1];
	assign plane       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NB-2:0], job_valid};
		end
	end

	assign shift_amt = (bl_s2 > BW'(MW)) ? bl_s2 - BW'(MW) : '0;

	always_ff @(posedge clk) begin
		if (adv) begin
			job_s1 <= job;
			orv_s1 <= job.cross_mag[0] | job.cross_mag[1] | job.cross_mag[2];
			job_s2 <= job_s1;
			bl_s2  <= bitlen(orv_s1);
			// scale all three by one shift so the largest fits the square stage
			side_s3.center     <= job_s2.center;
			side_s3.neg        <= job_s2.neg;
			side_s3.degenerate <= job_s2.degenerate;
			for (int i = 0; i < 3; i++) begin
				side_s3.mag[i] <= MW'(job_s2.cross_mag[i] >> shift_amt);
			end
			side_s4 <= side_s3;
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= side_s3.mag[i] * side_s3.mag[i];
			end
			side_s5 <= side_s4;
			sum_s5  <= SW'(sq_s4[0]) + SW'(sq_s4[1]) + SW'(sq_s4[2]);
		end
	end

	assign root_sr[0].rem  = sum_s5;
	assign root_sr[0].root = '0;
	assign side_sr[0]      = side_s5;

	for (genvar j = 1; j <= RW; j++) begin : g_root
		always_ff @(posedge clk) begin
			if (adv) begin
				root_sr[j] <= root_step(root_sr[j-1], SW'(1) << (SW - 2 * j));
				side_sr[j] <= side_sr[j-1];
			end
		end
	end

	// dividend rounds half away from zero: add half the root
	always_ff @(posedge clk) begin
		if (adv) begin
			side_sd[0] <= side_sr[RW];
			div_sd[0]  <= (root_sr[RW].root[RW-1:0] == '0) ? RW'(1) : root_sr[RW].root[RW-1:0];
			quo_sd[0]  <= '0;
			for (int i = 0; i < 3; i++) begin
				rem_sd[0][i] <= (DVW'(side_sr[RW].mag[i]) << NF)
					+ DVW'(root_sr[RW].root[RW-1:1]);
			end
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_div
		logic [DVW-1:0] dsh;
		assign dsh = DVW'(div_sd[j-1]) << (QW - j);
		always_ff @(posedge clk) begin
			if (adv) begin
				side_sd[j] <= side_sd[j-1];
				div_sd[j]  <= div_sd[j-1];
				for (int i = 0; i < 3; i++) begin
					if (rem_sd[j-1][i] >= dsh) begin
						rem_sd[j][i] <= rem_sd[j-1][i] - dsh;
						quo_sd[j][i] <= quo_sd[j-1][i] | (QW'(1) << (QW - j));
					end else begin
						rem_sd[j][i] <= rem_sd[j-1][i];
						quo_sd[j][i] <= quo_sd[j-1][i];
					end
				end
			end
		end
	end

	logic [2:0][QW-1:0] quo_sat;
	logic [2:0][NW-1:0] nrm;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			quo_sat[i] = (quo_sd[QW][i] > (QW'(1) << NF)) ? (QW'(1) << NF) : quo_sd[QW][i];
			if (side_sd[QW].degenerate) begin
				nrm[i] = '0;
			end else if (side_sd[QW].neg[i]) begin
				nrm[i] = NW'(quo_sat[i]);
			end else begin
				nrm[i] = NW'(0) - NW'(quo_sat[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.center_x   <= side_sd[QW].center[0];
			out_q.center_y   <= side_sd[QW].center[1];
			out_q.center_z   <= side_sd[QW].center[2];
			out_q.normal_x   <= nrm[0];
			out_q.normal_y   <= nrm[1];
			out_q.normal_z   <= nrm[2];
			out_q.degenerate <= side_sd[QW].degenerate;
		end
	end

endmodule

@@ hdl/quad_plane_centroid_normal.sv @@
// Plane from one quad: takes four signed Q16.16 corners and returns the centroid
// (exact four-way sum, floored divide by four) and the negated unit normal of
// (c1-c0) x (c2-c0) in signed Q2.14, with degenerate set and a zero normal when
// the cross product is zero. One quad is taken every cycle while quad_stall is
// low. A quad passes the front stages, the queue and then the back stages:
// scaling and squares, the bit-pair square root, forming the dividends, the
// quotient bits and the output register. The front keeps accepting into the
// QUEUE_DEPTH-entry queue while the plane output is stalled, until the queue
// is full.
module quad_plane_centroid_normal #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             quad_valid,
	output logic             quad_stall,
	input  qpcn_pkg::quad_t  quad,
	output logic             plane_valid,
	input  logic             plane_stall,
	output qpcn_pkg::plane_t plane
);

	logic                 job_valid, job_full, job_empty, job_pop;
	qpcn_pkg::plane_job_t job_wr, job_rd;

	qpcn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.quad_valid(quad_valid),
		.quad_stall(quad_stall),
		.quad      (quad),
		.job_valid (job_valid),
		.job_full  (job_full),
		.job       (job_wr)
	);

	qpcn_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_valid),
		.wr_data(job_wr),
		.full   (job_full),
		.pop    (job_pop),
		.rd_data(job_rd),
		.empty  (job_empty)
	);

	qpcn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (!job_empty),
		.job        (job_rd),
		.job_pop    (job_pop),
		.plane_valid(plane_valid),
		.plane_stall(plane_stall),
		.plane      (plane)
	);

	localparam logic signed [qpcn_pkg::NORMAL_WIDTH-1:0] UNIT =
		qpcn_pkg::NORMAL_WIDTH'(1) << qpcn_pkg::NORMAL_FRAC_BITS;

	assert property (@(posedge clk) disable iff (!arst_n)
		plane_valid && plane.degenerate |->
		plane.normal_x == '0 && plane.normal_y == '0 && plane.normal_z == '0)
		else $error("degenerate plane with nonzero normal");

	assert property (@(posedge clk) disable iff (!arst_n)
		plane_valid && !plane.degenerate |->
		plane.normal_x != '0 || plane.normal_y != '0 || plane.normal_z != '0)
		else $error("zero normal on a non-degenerate plane");

	assert property (@(posedge clk) disable iff (!arst_n)
		plane_valid |->
		plane.normal_x <= UNIT && plane.normal_x >= -UNIT &&
		plane.normal_y <= UNIT && plane.normal_y >= -UNIT &&
		plane.normal_z <= UNIT && plane.normal_z >= -UNIT)
		else $error("normal component beyond unit length");

	assert property (@(posedge clk) disable iff (!arst_n)
		quad_stall |-> job_full)
		else $error("front stalled while queue has room");

endmodule
